[hdl/spq_pkg.sv]
// spq_pkg: shared types and constants for the sorted priority queue
// no dependencies
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

[hdl/spq_in_if.sv]
// spq_in_if: input channel of the sorted priority queue
// depends on spq_pkg
interface spq_in_if;
    logic                              valid;
    logic                              ready;
    spq_pkg::t_action                  action;
    logic signed [spq_pkg::DATA_W-1:0] new_value;

    modport source (output valid, output action, output new_value, input ready);
    modport sink   (input valid, input action, input new_value, output ready);
endinterface

[hdl/spq_out_if.sv]
// spq_out_if: result channel of the sorted priority queue
// depends on spq_pkg
interface spq_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [spq_pkg::DATA_W-1:0] removed_value;
    spq_pkg::t_status                  status;
    logic [spq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output removed_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input occupancy,
                    output ready);
endinterface

[hdl/spq_cell.sv]
// spq_cell: one slot of the sorted chain, ascending from the rear of the queue
// depends on spq_pkg
module spq_cell (
    input  logic                              i_clk,
    input  spq_pkg::t_cell_ctrl               i_ctrl,
    input  logic                              i_valid,
    input  logic signed [spq_pkg::DATA_W-1:0] i_lower_value,
    input  logic                              i_lower_lt,
    input  logic signed [spq_pkg::DATA_W-1:0] i_upper_value,
    output logic signed [spq_pkg::DATA_W-1:0] o_value,
    output logic                              o_lt
);
    logic signed [spq_pkg::DATA_W-1:0] r_value;
    logic signed [spq_pkg::DATA_W-1:0] n_value;

    // stays in place on insert when strictly below the new value
    assign o_lt    = i_valid && (r_value < i_ctrl.value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins) begin
            if (o_lt) begin
                n_value = r_value;
            end else if (i_lower_lt) begin
                n_value = i_ctrl.value;
            end else begin
                n_value = i_lower_value;
            end
        end else if (i_ctrl.rem) begin
            n_value = i_upper_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end
endmodule

[hdl/sorted_priority_queue.sv]
// sorted_priority_queue: bounded priority queue built as a chain of compare cells
// depends on spq_pkg, spq_in_if, spq_out_if, spq_cell
//
// usage:
//   i_in carries one item per handshake: action (insert or remove smallest) and
//   new_value. o_out returns exactly one item for every input item: the removed
//   value (zero unless a value was taken out), a status code (ok, remove from
//   empty, insert into full) and the occupancy after the step, low 5 bits.
//   every cell compares its value with the new value in parallel and moves data
//   one place toward its neighbor, so a whole step is one update of the chain.
//   o_out.valid rises in the cycle after the input handshake; throughput is one
//   item per cycle while the receiver does not stall the output register.
//   the result sits in an output register; a new item is taken while it waits
//   only if the receiver takes the pending one in the same cycle.
//   when the receiver stalls, o_out holds its item and i_in.ready drops.
//   cell 0 holds the smallest value (rear of the queue), so a remove always
//   reads cell 0 and shifts the chain down by one.
//   reset (synchronous, active low) empties the queue and the output register;
//   cell contents are not cleared, the count decides which cells hold data.
//   equal values: a new value lands nearer the rear than stored equals.
//
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // output register
    logic                              r_out_valid;
    logic signed [spq_pkg::DATA_W-1:0] r_removed;
    spq_pkg::t_status                  r_status;
    logic [spq_pkg::OCC_W-1:0]         r_occ;

    logic                              accept;
    logic                              full;
    logic                              empty;
    spq_pkg::t_cell_ctrl               ctrl;
    spq_pkg::t_status                  n_status;
    logic [CNT_W+spq_pkg::OCC_W-1:0]   occ_ext;

    logic                              cell_valid [CAPACITY];
    logic                              cell_lt    [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] cell_value [CAPACITY];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);

    // control broadcast to all cells
    always_comb begin
        ctrl.ins   = accept && (i_in.action == spq_pkg::ACT_INSERT) && !full;
        ctrl.rem   = accept && (i_in.action == spq_pkg::ACT_REMOVE) && !empty;
        ctrl.value = i_in.new_value;
    end

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        unique case (i_in.action)
            spq_pkg::ACT_INSERT: begin
                if (full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            spq_pkg::ACT_REMOVE: begin
                if (empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count  = r_count;
                n_status = spq_pkg::ST_OK;
            end
        endcase
    end

    // occupancy reported modulo 32
    assign occ_ext = {{spq_pkg::OCC_W{1'b0}}, n_count};

    // the chain: cell 0 is the rear (smallest), higher cells hold larger values
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic signed [spq_pkg::DATA_W-1:0] lower_value;
        logic                              lower_lt;
        logic signed [spq_pkg::DATA_W-1:0] upper_value;

        assign cell_valid[j] = (CNT_W'(j) < r_count);

        if (j == 0) begin : g_first
            assign lower_value = '0;
            assign lower_lt    = 1'b1;
        end else begin : g_mid
            assign lower_value = cell_value[j-1];
            assign lower_lt    = cell_lt[j-1];
        end

        if (j == CAPACITY - 1) begin : g_last
            assign upper_value = '0;
        end else begin : g_body
            assign upper_value = cell_value[j+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_valid       (cell_valid[j]),
            .i_lower_value (lower_value),
            .i_lower_lt    (lower_lt),
            .i_upper_value (upper_value),
            .o_value       (cell_value[j]),
            .o_lt          (cell_lt[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed <= ctrl.rem ? cell_value[0] : '0;
            r_status  <= n_status;
            r_occ     <= occ_ext[spq_pkg::OCC_W-1:0];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.removed_value = r_removed;
    assign o_out.status        = r_status;
    assign o_out.occupancy     = r_occ;
endmodule

[hdl/spq_checker.sv]
// spq_checker: port-level assertions for sorted_priority_queue, attached by bind
// depends on spq_pkg
module spq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [spq_pkg::DATA_W-1:0] i_removed_value,
    input logic [1:0]                        i_status,
    input logic [spq_pkg::OCC_W-1:0]         i_occupancy
);
    // every accepted item shows a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("no result after accepted item");

    // remove from empty reports zero value and an empty queue
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == spq_pkg::ST_EMPTY) |->
            (i_removed_value == '0 && i_occupancy == '0))
        else $error("bad remove-from-empty result");

    // a full-queue insert never carries a removed value
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == spq_pkg::ST_FULL) |-> (i_removed_value == '0))
        else $error("full insert reports a removed value");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_removed_value) && $stable(i_status)
             && $stable(i_occupancy)))
        else $error("stalled result changed");
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_removed_value (o_out.removed_value),
    .i_status        (o_out.status),
    .i_occupancy     (o_out.occupancy)
);

[verif/spq_scoreboard.sv]
`timescale 1ns / 1ps
// spq_tb_pkg: shadow copy of the sorted priority queue and its result checker
// depends on spq_pkg
package spq_tb_pkg;

    typedef struct {
        logic signed [spq_pkg::DATA_W-1:0] removed_value;
        spq_pkg::t_status                  status;
        logic [spq_pkg::OCC_W-1:0]         occupancy;
    } t_queue_result;

    class spq_shadow_queue;
        // ascending order, index 0 is the smallest value (rear of the queue)
        logic signed [spq_pkg::DATA_W-1:0] stored_values[$];
        t_queue_result                     pending_results[$];
        int                                error_count;

        function new();
            error_count = 0;
        endfunction

        // work out the result of one accepted item and update the shadow copy
        function void note_item(spq_pkg::t_action act,
                                logic signed [spq_pkg::DATA_W-1:0] value);
            t_queue_result res;
            int            pos;
            res.removed_value = '0;
            res.status        = spq_pkg::ST_OK;
            if (act == spq_pkg::ACT_INSERT) begin
                if (stored_values.size() >= spq_pkg::CAPACITY) begin
                    res.status = spq_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < stored_values.size() && stored_values[pos] < value)
                        pos++;
                    stored_values.insert(pos, value);
                end
            end else begin
                if (stored_values.size() == 0) begin
                    res.status = spq_pkg::ST_EMPTY;
                end else begin
                    res.removed_value = stored_values.pop_front();
                end
            end
            res.occupancy = spq_pkg::OCC_W'(stored_values.size());
            pending_results.push_back(res);
        endfunction

        function void check_result(logic signed [spq_pkg::DATA_W-1:0] got_removed,
                                   spq_pkg::t_status got_status,
                                   logic [spq_pkg::OCC_W-1:0] got_occ);
            t_queue_result want;
            if (pending_results.size() == 0) begin
                $error("result item with nothing outstanding: removed_value %0d", got_removed);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got_removed !== want.removed_value) begin
                $error("removed_value: expected %0d, actual %0d", want.removed_value,
                       got_removed);
                error_count++;
            end
            if (got_status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got_status);
                error_count++;
            end
            if (got_occ !== want.occupancy) begin
                $error("occupancy: expected %0d, actual %0d", want.occupancy, got_occ);
                error_count++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

endpackage

[verif/tb.sv]
`timescale 1ns / 1ps
// tb: directed and random test of sorted_priority_queue against a shadow queue
// depends on spq_pkg, spq_in_if, spq_out_if, spq_tb_pkg and the block itself
module tb;

    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 285;

    logic i_clk;
    logic i_rst_n;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    spq_tb_pkg::spq_shadow_queue sb = new();

    // idle odds in percent, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, requested by the sender side, served by the receiver
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    always #5 i_clk = ~i_clk;

    // receiver: ready changes on the falling edge
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !($urandom_range(99) < recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.removed_value, out_ch.status, out_ch.occupancy);
    end

    // offer one item, hold it until the block takes it
    task automatic send_item(spq_pkg::t_action act,
                             logic signed [spq_pkg::DATA_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.new_value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(act, value);
    endtask

    // mix of full-range values, small values that collide often, and the extremes
    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
        logic signed [spq_pkg::DATA_W-1:0] v;
        case ($urandom_range(3))
            0, 1: v = $urandom();
            2:    v = int'($urandom_range(6)) - 3;
            default: begin
                case ($urandom_range(3))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = 32'sh7FFF_FFFE;
                    default: v = 32'sh8000_0001;
                endcase
            end
        endcase
        return v;
    endfunction

    // segments with different insert odds so the queue swings between empty and full
    task automatic run_random(int n_items);
        int done_cnt;
        int seg_len;
        int ins_pct;
        done_cnt = 0;
        while (done_cnt < n_items) begin
            seg_len = $urandom_range(8, 40);
            case ($urandom_range(3))
                0:       ins_pct = 10;
                1:       ins_pct = 50;
                2:       ins_pct = 80;
                default: ins_pct = 97;
            endcase
            for (int k = 0; k < seg_len && done_cnt < n_items; k++) begin
                if ($urandom_range(99) < ins_pct)
                    send_item(spq_pkg::ACT_INSERT, pick_value());
                else
                    send_item(spq_pkg::ACT_REMOVE, $urandom());
                done_cnt++;
            end
        end
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.action    = spq_pkg::ACT_INSERT;
        in_ch.new_value = '0;
        out_ch.ready    = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: remove from empty, extremes and duplicates, drain in order
        send_item(spq_pkg::ACT_REMOVE, 32'sh0);
        send_item(spq_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
        send_item(spq_pkg::ACT_INSERT, 32'sh8000_0000);
        send_item(spq_pkg::ACT_INSERT, 32'sh0);
        send_item(spq_pkg::ACT_INSERT, -32'sd1);
        send_item(spq_pkg::ACT_INSERT, 32'sd1);
        send_item(spq_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
        send_item(spq_pkg::ACT_INSERT, 32'sh8000_0000);
        send_item(spq_pkg::ACT_INSERT, 32'sh5555_5555);
        send_item(spq_pkg::ACT_INSERT, 32'shAAAA_AAAA);
        repeat (9) send_item(spq_pkg::ACT_REMOVE, 32'shFFFF_FFFF);
        send_item(spq_pkg::ACT_REMOVE, 32'sh0);

        // no idling, with one long receiver hold-off in the middle
        run_random(100);
        hold_requests++;
        run_random(PHASE_ITEMS - 100);

        send_idle_pct = 81;
        run_random(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 81;
        run_random(PHASE_ITEMS);

        send_idle_pct  = 30;
        recv_stall_pct = 30;
        run_random(PHASE_ITEMS);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (sb.error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
